@@ rtl/combined_lcg_shuffle_rng_macros.svh @@
// Assertion macros for the combined LCG shuffle generator.
// Included by the controller and the datapath; no other dependencies.
`ifndef COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH

// same-cycle implication, disabled during reset
`define CLSRNG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CLSRNG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/clsrng_pkg.sv @@
// Shared types and constants for the combined LCG shuffle generator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package clsrng_pkg;

   localparam int WORD_W          = 32;   // caller's generator word
   localparam int GEN_W           = 31;   // generator / sample width
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int WARM_EXTRA      = 8;    // warm-up steps beyond the table depth
   localparam int SCH_LAT         = 4;    // Schrage pipeline latency
   localparam int SL_SHIFT        = 32;   // reciprocal scaling shift

   localparam int MULT_W      = 16;
   localparam int QUOT_W      = 16;
   localparam int RESID_W     = 14;
   localparam int SCH_RECIP_W = 17;
   localparam int K_W         = 16;   // quotient x / q
   localparam int REMD_W      = 17;   // remainder before correction, < 2q

   localparam logic [GEN_W-1:0] IM1         = 31'd2147483563;
   localparam logic [GEN_W-1:0] WRAP1       = 31'd2147483562;
   localparam logic [GEN_W-1:0] SEED2_RESET = 31'd123456789;
   localparam logic [GEN_W-1:0] MAG_MAX     = 31'h7FFF_FFFF;
   localparam logic [GEN_W-1:0] MAG_MIN     = 31'd1;

   typedef struct packed {
      logic [MULT_W-1:0]      mult;
      logic [QUOT_W-1:0]      quot;
      logic [RESID_W-1:0]     resid;
      logic [GEN_W-1:0]       modulus;
      logic [SCH_RECIP_W-1:0] recip;    // floor(2^32 / quot)
   } lcg_const_type;

   localparam lcg_const_type GEN1_CONST = '{
      mult: 16'd40014, quot: 16'd53668, resid: 14'd12211,
      modulus: 31'd2147483563, recip: 17'd80028};

   localparam lcg_const_type GEN2_CONST = '{
      mult: 16'd40692, quot: 16'd52774, resid: 14'd3791,
      modulus: 31'd2147483399, recip: 17'd81384};

   typedef struct packed {
      logic capture;      // latch the incoming word
      logic seed;         // load both generators with the seed magnitude
      logic take;         // load generator 1 with the caller's word
      logic warm_store;   // warm-up step done: advance, fill table
      logic finish;       // draw done: update state, load result
   } clsrng_cmd_type;

   typedef struct packed {
      logic word_nonpos;  // latched word is zero or negative
      logic warm_last;    // final warm-up step
   } clsrng_stat_type;

endpackage

@@ rtl/clsrng_if.sv @@
// Request and response channel interfaces for the combined LCG generator.
// Depends on clsrng_pkg.
`timescale 1ns / 1ps

interface clsrng_req_if;
   import clsrng_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] generator_word;
   modport source (output valid, output generator_word, input ready);
   modport sink   (input valid, input generator_word, output ready);
endinterface

interface clsrng_rsp_if;
   import clsrng_pkg::*;
   logic             valid;
   logic             ready;
   logic [GEN_W-1:0] next_generator_word;
   logic [GEN_W-1:0] sample;
   modport source (output valid, output next_generator_word, output sample, input ready);
   modport sink   (input valid, input next_generator_word, input sample, output ready);
endinterface

@@ rtl/clsrng_schrage.sv @@
// Four-stage pipelined Schrage step y = a*(x mod q) - r*(x div q), +m if negative.
// Depends on clsrng_pkg. Quotient via reciprocal multiply with one correction.
`timescale 1ns / 1ps

module clsrng_schrage #(
   parameter clsrng_pkg::lcg_const_type CFG = clsrng_pkg::GEN1_CONST
) (
   input  logic                         clock,
   input  logic [clsrng_pkg::GEN_W-1:0] x,
   output logic [clsrng_pkg::GEN_W-1:0] y
);
   import clsrng_pkg::*;

   localparam int P1_W = GEN_W + SCH_RECIP_W;
   localparam int P2_W = K_W + QUOT_W;
   localparam int TA_W = K_W + MULT_W;
   localparam int TB_W = K_W + RESID_W;
   localparam int SUM_W = TA_W + 1;

   logic [K_W-1:0]    est_ff;
   logic [GEN_W-1:0]  xs_ff;
   logic [REMD_W-1:0] rem_ff;
   logic [K_W-1:0]    k_ff;
   logic [TA_W-1:0]   ta_ff;
   logic [TB_W-1:0]   tb_ff;
   logic [GEN_W-1:0]  y_ff;

   logic [P1_W-1:0]   prod1;
   logic [P2_W-1:0]   prod2;
   logic [P2_W-1:0]   rem_full;
   logic              rem_ge;
   logic [REMD_W-1:0] rem_sub;
   logic [K_W-1:0]    k_corr;
   logic [K_W-1:0]    rem_corr;
   logic [SUM_W-1:0]  diff;
   logic [SUM_W-1:0]  diff_wrap;

   always_comb begin
      // stage 1: quotient estimate, exact or one low
      prod1 = P1_W'(x) * P1_W'(CFG.recip);
      // stage 2: remainder of the estimate
      prod2 = P2_W'(est_ff) * P2_W'(CFG.quot);
      rem_full = P2_W'(xs_ff) - prod2;
      // stage 3: correct quotient and remainder
      rem_ge = rem_ff >= REMD_W'(CFG.quot);
      rem_sub = rem_ge ? rem_ff - REMD_W'(CFG.quot) : rem_ff;
      rem_corr = rem_sub[K_W-1:0];
      k_corr = k_ff + K_W'(rem_ge);
      // stage 4: combine and fold into range
      diff = SUM_W'(ta_ff) - SUM_W'(tb_ff);
      diff_wrap = diff[SUM_W-1] ? diff + SUM_W'(CFG.modulus) : diff;
   end

   always_ff @(posedge clock) begin
      est_ff <= prod1[SL_SHIFT +: K_W];
      xs_ff  <= x;
      rem_ff <= rem_full[REMD_W-1:0];
      k_ff   <= est_ff;
      ta_ff  <= TA_W'(rem_corr) * TA_W'(CFG.mult);
      tb_ff  <= TB_W'(k_corr) * TB_W'(CFG.resid);
      y_ff   <= diff_wrap[GEN_W-1:0];
   end

   assign y = y_ff;

endmodule

@@ rtl/clsrng_datapath.sv @@
// Datapath: two Schrage pipelines, shuffle table memory, slot divider, result registers.
// Depends on clsrng_pkg, clsrng_schrage and the assertion macro header.
`timescale 1ns / 1ps
`include "combined_lcg_shuffle_rng_macros.svh"

module clsrng_datapath #(
   parameter int TABLE_DEPTH = clsrng_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  clsrng_pkg::clsrng_cmd_type           cmd,
   output clsrng_pkg::clsrng_stat_type          stat,
   input  logic signed [clsrng_pkg::WORD_W-1:0] req_word,
   output logic [clsrng_pkg::GEN_W-1:0]         out_word,
   output logic [clsrng_pkg::GEN_W-1:0]         out_sample
);
   import clsrng_pkg::*;

   localparam int     IDX_W    = $clog2(TABLE_DEPTH);
   localparam int     CNT_W    = $clog2(TABLE_DEPTH + WARM_EXTRA);
   localparam longint BUCKET   = 1 + longint'(WRAP1) / TABLE_DEPTH;
   localparam longint SL_RECIP = (longint'(1) << SL_SHIFT) / BUCKET;
   localparam int     RECIP_W  = $clog2(SL_RECIP + 1);
   localparam int     PROD_W   = GEN_W + RECIP_W;
   localparam logic [RECIP_W-1:0] SL_RECIP_V = RECIP_W'(SL_RECIP);
   localparam logic [GEN_W-1:0]   BUCKET_V   = GEN_W'(BUCKET);
   localparam logic [CNT_W-1:0]   CNT_START  = CNT_W'(TABLE_DEPTH + WARM_EXTRA - 1);
   localparam logic [CNT_W-1:0]   CNT_DEPTH  = CNT_W'(TABLE_DEPTH);
   localparam logic [IDX_W:0]     SLOT_MAX   = (IDX_W + 1)'(TABLE_DEPTH - 1);

   logic signed [WORD_W-1:0] in_ff;
   logic [GEN_W-1:0]         x_ff;
   logic [GEN_W-1:0]         sg_ff;
   logic [GEN_W-1:0]         lo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [IDX_W-1:0]         est_ff;
   logic [GEN_W-1:0]         lo_s_ff;
   logic [IDX_W-1:0]         slot_ff;
   logic [GEN_W-1:0]         rd_ff;
   logic                     rd_vld_ff;
   logic [TABLE_DEPTH-1:0]   shuf_vld_ff;
   logic [GEN_W-1:0]         shuf_mem [TABLE_DEPTH];
   logic [GEN_W-1:0]         out_word_ff;
   logic [GEN_W-1:0]         out_sample_ff;

   logic [GEN_W-1:0]  y1;
   logic [GEN_W-1:0]  y2;
   logic [WORD_W-1:0] neg_word;
   logic [GEN_W-1:0]  mag;
   logic [PROD_W-1:0] sl_prod;
   logic [GEN_W-1:0]  sl_mul;
   logic [GEN_W-1:0]  sl_rem;
   logic [IDX_W:0]    slot_sum;
   logic [IDX_W-1:0]  slot_next;
   logic [GEN_W-1:0]  entry;
   logic [GEN_W+1:0]  diff;
   logic [GEN_W+1:0]  diff_wrap;
   logic              fill_we;
   logic              mem_we;
   logic [IDX_W-1:0]  wr_addr;

   clsrng_schrage #(.CFG(GEN1_CONST)) u_gen1 (.clock(clock), .x(x_ff),  .y(y1));
   clsrng_schrage #(.CFG(GEN2_CONST)) u_gen2 (.clock(clock), .x(sg_ff), .y(y2));

   always_comb begin
      // seed magnitude, saturated to 31 bits, at least one
      neg_word = WORD_W'(-in_ff);
      if (in_ff == '0) begin
         mag = MAG_MIN;
      end else if (neg_word[WORD_W-1]) begin
         mag = MAG_MAX;
      end else begin
         mag = neg_word[GEN_W-1:0];
      end

      // slot = last_output / BUCKET, reciprocal estimate plus one correction
      sl_prod = PROD_W'(lo_ff) * PROD_W'(SL_RECIP_V);
      sl_mul = GEN_W'(est_ff) * BUCKET_V;
      sl_rem = lo_s_ff - sl_mul;
      slot_sum = (IDX_W + 1)'(est_ff) + (IDX_W + 1)'(sl_rem >= BUCKET_V);
      slot_next = (slot_sum > SLOT_MAX) ? SLOT_MAX[IDX_W-1:0] : slot_sum[IDX_W-1:0];

      // entry minus second generator, wrapped into 1..IM1-1
      entry = rd_vld_ff ? rd_ff : '0;
      diff = (GEN_W + 2)'(entry) - (GEN_W + 2)'(y2);
      diff_wrap = (diff[GEN_W+1] || diff == '0) ? diff + (GEN_W + 2)'(WRAP1) : diff;

      fill_we = cmd.warm_store && (cnt_ff < CNT_DEPTH);
      mem_we = fill_we || cmd.finish;
      wr_addr = cmd.finish ? slot_ff : cnt_ff[IDX_W-1:0];

      stat.word_nonpos = in_ff[WORD_W-1] || (in_ff == '0);
      stat.warm_last = (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_ff <= SEED2_RESET;
         lo_ff <= '0;
         shuf_vld_ff <= '0;
      end else begin
         if (cmd.seed) begin
            sg_ff <= mag;
         end else if (cmd.finish) begin
            sg_ff <= y2;
         end
         if (cmd.warm_store && stat.warm_last) begin
            lo_ff <= y1;
         end else if (cmd.finish) begin
            lo_ff <= diff_wrap[GEN_W-1:0];
         end
         if (mem_we) begin
            shuf_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_word;
      end
      if (cmd.seed) begin
         x_ff <= mag;
         cnt_ff <= CNT_START;
      end else if (cmd.take) begin
         x_ff <= in_ff[GEN_W-1:0];
      end else if (cmd.warm_store) begin
         x_ff <= y1;
         cnt_ff <= cnt_ff - 1'b1;
      end
      est_ff  <= sl_prod[SL_SHIFT +: IDX_W];
      lo_s_ff <= lo_ff;
      slot_ff <= slot_next;
      if (cmd.finish) begin
         out_word_ff <= y1;
         out_sample_ff <= diff_wrap[GEN_W-1:0];
      end
   end

   // shuffle table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         shuf_mem[wr_addr] <= y1;
      end
      rd_ff <= shuf_mem[slot_ff];
      rd_vld_ff <= shuf_vld_ff[slot_ff];
   end

   assign out_word = out_word_ff;
   assign out_sample = out_sample_ff;

   `CLSRNG_ASSERT_NEXT(a_seed_output, clock, reset, cmd.warm_store && stat.warm_last,
      lo_ff == $past(y1), "last output not taken from table entry zero after warm-up")
   `CLSRNG_ASSERT_NEXT(a_sample_range, clock, reset, cmd.finish,
      (out_sample_ff != '0) && (out_sample_ff <= WRAP1), "sample outside 1..IM1-1")
   `CLSRNG_ASSERT_NEXT(a_gen2_advance, clock, reset, cmd.finish,
      sg_ff == $past(y2), "second generator not advanced by a finished draw")

endmodule

@@ rtl/clsrng_ctrl.sv @@
// Controller state machine: sequences capture, warm-up, draw and result handoff.
// Depends on clsrng_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "combined_lcg_shuffle_rng_macros.svh"

module clsrng_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  clsrng_pkg::clsrng_stat_type stat,
   output clsrng_pkg::clsrng_cmd_type  cmd
);
   import clsrng_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_WARM   = 3'd2;
   localparam logic [2:0] ST_WSTORE = 3'd3;
   localparam logic [2:0] ST_DRAW   = 3'd4;
   localparam logic [2:0] ST_FIN    = 3'd5;

   localparam int         WAIT_W    = $clog2(SCH_LAT);
   localparam logic [WAIT_W-1:0] WAIT_LAST = WAIT_W'(SCH_LAT - 1);

   logic [2:0]        state_ff, state_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      cmd = '0;
      req_ready = 1'b0;
      out_free = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            wait_in = '0;
            if (stat.word_nonpos) begin
               cmd.seed = 1'b1;
               state_in = ST_WARM;
            end else begin
               cmd.take = 1'b1;
               state_in = ST_DRAW;
            end
         end
         ST_WARM: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WAIT_LAST) begin
               state_in = ST_WSTORE;
            end
         end
         ST_WSTORE: begin
            cmd.warm_store = 1'b1;
            wait_in = '0;
            state_in = stat.warm_last ? ST_DRAW : ST_WARM;
         end
         ST_DRAW: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WAIT_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `CLSRNG_ASSERT_IMPL(a_fin_free, clock, reset, cmd.finish,
      !rsp_valid_ff || rsp_ready, "result overwritten while still pending")
   `CLSRNG_ASSERT_NEXT(a_fin_valid, clock, reset, cmd.finish,
      rsp_valid_ff, "finished draw did not raise response valid")
   `CLSRNG_ASSERT_NEXT(a_seed_warm, clock, reset, cmd.seed,
      (state_ff == ST_WARM) && (wait_ff == '0), "seed did not start a clean warm-up step")

endmodule

@@ rtl/combined_lcg_shuffle_rng.sv @@
// Top level of the combined LCG generator with shuffle table.
// Depends on clsrng_pkg, clsrng_if, clsrng_ctrl and clsrng_datapath.
`timescale 1ns / 1ps

// Combined two-generator multiplicative LCG with a Bays-Durham shuffle table,
// integer core only. Each request transaction carries the caller's generator
// word and produces exactly one response transaction with the updated word and
// a raw sample in 1..IM1-1 (scale by 1/IM1 in software). One transaction is
// in flight at a time; the response sits in an output register, so the next
// request is taken while the previous response is still waiting. A normal draw
// runs from request accept to the next possible accept through these steps:
// accept, load, a trip through the Schrage pipeline (both generators run in
// parallel), and a finish step that waits until the output register is free,
// then updates the table and loads the response. A word that is zero or
// negative reseeds first with a warm-up pass that fills the table; each step
// is a full trip through the same 4-stage Schrage pipeline plus a store step.
// Reset clears the table via per-entry valid bits and seeds generator 2, so
// no clearing pass is needed and a request is taken right after reset.
module combined_lcg_shuffle_rng #(
   parameter int TABLE_DEPTH = clsrng_pkg::TABLE_DEPTH_DEF
) (
   input logic          clock,
   input logic          reset,
   clsrng_req_if.sink   req_ch,
   clsrng_rsp_if.source rsp_ch
);
   import clsrng_pkg::*;

   // control / status between the sequencer and the datapath
   clsrng_cmd_type  cmd;
   clsrng_stat_type stat;

   logic             req_ready;
   logic             rsp_valid;
   logic [GEN_W-1:0] out_word;
   logic [GEN_W-1:0] out_sample;

   // sequencer: owns the handshake and the step timing
   clsrng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: generators, shuffle table, slot select, result registers
   clsrng_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_word   (req_ch.generator_word),
      .out_word   (out_word),
      .out_sample (out_sample)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign rsp_ch.next_generator_word = out_word;
   assign rsp_ch.sample = out_sample;

endmodule

@@ sim/tb_combined_lcg_shuffle_rng.sv @@
// Self-checking testbench for combined_lcg_shuffle_rng: directed seeding and
// word-range cases, then random seeded draw chains under random flow control.
// Depends on clsrng_pkg, clsrng_if and the combined_lcg_shuffle_rng RTL.
`timescale 1ns / 1ps

module tb_combined_lcg_shuffle_rng;
   import clsrng_pkg::*;

   localparam int     DEPTH          = TABLE_DEPTH_DEF;
   localparam longint BUCKET_SIZE    = 64'sd1 + longint'(WRAP1) / DEPTH;
   localparam int     MAX_WAIT       = 14;
   localparam int     HOLD_OFF_LEN   = 400;   // long output stall, in cycles
   localparam int     DRAIN_CYCLES   = 250;   // a bit over one reseed draw
   localparam int     RANDOM_ITEMS   = 1330;
   localparam longint RUN_LIMIT_NS   = 64'd20_000_000;

   typedef struct {
      logic [GEN_W-1:0] next_word;
      logic [GEN_W-1:0] sample;
   } draw_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   clsrng_req_if req_ch ();
   clsrng_rsp_if rsp_ch ();

   combined_lcg_shuffle_rng dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // ---------------------------------------------------------------------
   // Predictor state: mirror of the generator pair and the shuffle table
   // ---------------------------------------------------------------------
   logic [GEN_W-1:0] gen2_state  = SEED2_RESET;
   logic [GEN_W-1:0] last_sample = '0;
   logic [GEN_W-1:0] shuffle_tbl [DEPTH];
   logic [GEN_W-1:0] chain_word  = '0;   // word a caller would pass back next

   draw_result_type pending_draws [$];
   int           mismatch_count = 0;
   bit           no_idle        = 1'b0;   // back-to-back stretch on both sides
   int           hold_off_req   = 0;      // receiver stall request, in cycles

   initial begin
      for (int i = 0; i < DEPTH; i++) shuffle_tbl[i] = '0;
   end

   // One Schrage step: a*(x - k*q) - r*k, plus the modulus when negative.
   function automatic longint lcg_step(input longint x, input lcg_const_type c);
      longint k;
      longint y;
      k = x / longint'(c.quot);
      y = longint'(c.mult) * (x - k * longint'(c.quot)) - longint'(c.resid) * k;
      if (y < 0) y += longint'(c.modulus);
      return y;
   endfunction

   // Advance the mirrored state by one request transaction.
   task automatic predict_draw(input logic signed [WORD_W-1:0] w,
                               output draw_result_type r);
      longint x;
      longint mag;
      longint g2;
      longint diff;
      longint slot;
      int     i;
      x = longint'(w);
      if (x <= 0) begin
         // reseed: magnitude clamped to 1..2^31-1, warm-up fills the table
         mag = -x;
         if (mag < 1) mag = 1;
         if (mag > longint'(MAG_MAX)) mag = longint'(MAG_MAX);
         x = mag;
         gen2_state = mag[GEN_W-1:0];
         for (i = DEPTH + WARM_EXTRA - 1; i >= 0; i--) begin
            x = lcg_step(x, GEN1_CONST);
            if (i < DEPTH) shuffle_tbl[i] = x[GEN_W-1:0];
         end
         last_sample = shuffle_tbl[0];
      end
      x  = lcg_step(x, GEN1_CONST);
      g2 = lcg_step(longint'(gen2_state), GEN2_CONST);
      slot = longint'(last_sample) / BUCKET_SIZE;
      if (slot > DEPTH - 1) slot = DEPTH - 1;
      diff = longint'(shuffle_tbl[slot]) - g2;
      shuffle_tbl[slot] = x[GEN_W-1:0];
      if (diff < 1) diff += longint'(WRAP1);
      gen2_state  = g2[GEN_W-1:0];
      last_sample = diff[GEN_W-1:0];
      r.next_word = x[GEN_W-1:0];
      r.sample    = diff[GEN_W-1:0];
   endtask

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      mismatch_count++;
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Request side: random gap, then hold valid until the transaction is taken
   // ---------------------------------------------------------------------
   task automatic send_word(input logic signed [WORD_W-1:0] w);
      int           gap;
      draw_result_type r;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid          <= 1'b1;
      req_ch.generator_word <= w;
      do @(posedge clock); while (!req_ch.ready);
      predict_draw(w, r);
      pending_draws.push_back(r);
      chain_word = r.next_word;
   endtask

   // Sender pause: drop valid so the last word is not taken again, then drain.
   task automatic wait_all_drawn();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall per transaction, or a long hold-off
   // ---------------------------------------------------------------------
   initial begin : rsp_receiver
      int stall;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         if (hold_off_req > 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (hold_off_req - 1) @(negedge clock);
            hold_off_req = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
               @(negedge clock);
               rsp_ch.ready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Compare every response transaction with the oldest predicted draw.
   always @(posedge clock) begin : rsp_checker
      draw_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_draws.size() == 0) begin
            report_mismatch("response with no pending draw, sample",
                            longint'(rsp_ch.sample), 0);
         end else begin
            want = pending_draws.pop_front();
            if (rsp_ch.next_generator_word !== want.next_word)
               report_mismatch("next_generator_word",
                                longint'(rsp_ch.next_generator_word),
                                longint'(want.next_word));
            if (rsp_ch.sample !== want.sample)
               report_mismatch("sample", longint'(rsp_ch.sample),
                               longint'(want.sample));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Draws straight after reset run on the cleared table and reset second generator.
   task automatic test_draw_before_seed();
      send_word(32'sd1);
      send_word(32'sd2147483562);
   endtask

   // Zero, minus one, most negative (saturated magnitude) and most negative
   // representable magnitude, each followed by chained draws.
   task automatic test_reseed_extremes();
      send_word(32'sd0);
      send_word(chain_word);
      send_word(-32'sd1);
      send_word(chain_word);
      wait_all_drawn();   // sender pause with the block fully drained
      send_word(32'sh8000_0000);
      send_word(chain_word);
      send_word(chain_word);
      send_word(-32'sd2147483647);
      send_word(chain_word);
   endtask

   // Positive words at and above the first modulus; IM1 steps to zero, and
   // handing that zero back reseeds.
   task automatic test_large_words();
      send_word(32'sd2147483563);
      send_word(chain_word);
      send_word(32'sh7FFF_FFFF);
      send_word(chain_word);
   endtask

   // Receiver holds off while the sender keeps offering back to back, so the
   // output register fills and the request side stalls.
   task automatic test_output_stall();
      wait_all_drawn();
      hold_off_req = HOLD_OFF_LEN;
      no_idle      = 1'b1;
      send_word(-32'sd777);
      repeat (5) send_word(chain_word);
      no_idle = 1'b0;
      wait_all_drawn();
   endtask

   // Mostly reseed-then-chain sequences, with noise words and broken chains.
   task automatic test_random_sequences();
      int                       sent;
      int                       chain_len;
      int                       kind;
      int                       k;
      logic signed [WORD_W-1:0] w;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 5) == 0);
         kind    = $urandom_range(0, 9);
         if (kind == 0) begin
            // noise: arbitrary 32-bit words, either sign
            chain_len = $urandom_range(1, 4);
            for (k = 0; k < chain_len; k++) begin
               w = $urandom;
               send_word(w);
            end
         end else begin
            case ($urandom_range(0, 3))
               0:       w = $urandom | 32'h8000_0000;
               1:       w = -$signed($urandom_range(0, 1000));
               2:       w = 32'sd0;
               default: w = -$signed(32'($urandom_range(0, 32'h7FFF_FFFF)));
            endcase
            send_word(w);
            chain_len = $urandom_range(8, 48);
            for (k = 0; k < chain_len; k++) begin
               if ($urandom_range(0, 29) == 0)
                  send_word($signed(32'($urandom_range(1, 32'h7FFF_FFFF))));
               else
                  send_word(chain_word);
            end
            sent += chain_len;
         end
         sent += (kind == 0) ? chain_len : 1;
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   initial begin : sequencer
      req_ch.valid          = 1'b0;
      req_ch.generator_word = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_draw_before_seed();
      test_reseed_extremes();
      test_large_words();
      test_output_stall();
      test_random_sequences();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_all_drawn();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("combined_lcg_shuffle_rng verification clean");
      end else begin
         $display("combined_lcg_shuffle_rng verification failed");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("combined_lcg_shuffle_rng verification failed");
      $finish;
   end

endmodule
